// ----- rtl/core/irpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg: shared types and constants for the IR pulse-distance transmitter
// Item kinds, register indexes, phase codes, config struct and segment length
// clamping used by the top level and the sequencer.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int TIMER_BITS = 17;
  localparam int FRAME_BITS = 32;

  localparam int WORD_W  = 32;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 3;
  localparam int BL_W    = $clog2(FRAME_BITS + 1);
  localparam int EXT_W   = (CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS;

  // Item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_REPEAT = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_UNIT       = 3'd0;
  localparam logic [CIDX_W-1:0] REG_LONG       = 3'd1;
  localparam logic [CIDX_W-1:0] REG_LEAD_MARK  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LEAD_SPACE = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REP_SPACE  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_FRAME_GAP  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_REP_GAP    = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_UNIT       = 17'd562;
  localparam logic [CFG_W-1:0] RST_LONG       = 17'd1675;
  localparam logic [CFG_W-1:0] RST_LEAD_MARK  = 17'd9000;
  localparam logic [CFG_W-1:0] RST_LEAD_SPACE = 17'd4500;
  localparam logic [CFG_W-1:0] RST_REP_SPACE  = 17'd2250;
  localparam logic [CFG_W-1:0] RST_FRAME_GAP  = 17'd40000;
  localparam logic [CFG_W-1:0] RST_REP_GAP    = 17'd96187;

  // Phase codes
  localparam logic [3:0] PH_IDLE          = 4'd0;
  localparam logic [3:0] PH_LEAD_MARK     = 4'd1;
  localparam logic [3:0] PH_LEAD_SPACE    = 4'd2;
  localparam logic [3:0] PH_BIT_MARK      = 4'd3;
  localparam logic [3:0] PH_BIT_SPACE     = 4'd4;
  localparam logic [3:0] PH_TRAIL_MARK    = 4'd5;
  localparam logic [3:0] PH_FRAME_GAP     = 4'd6;
  localparam logic [3:0] PH_REP_LEAD_MARK = 4'd7;
  localparam logic [3:0] PH_REP_SPACE     = 4'd8;
  localparam logic [3:0] PH_REP_MARK      = 4'd9;
  localparam logic [3:0] PH_REP_GAP       = 4'd10;

  typedef struct packed {
    logic [CFG_W-1:0] unit_mark;
    logic [CFG_W-1:0] long_space;
    logic [CFG_W-1:0] leader_mark;
    logic [CFG_W-1:0] leader_space;
    logic [CFG_W-1:0] repeat_space;
    logic [CFG_W-1:0] frame_gap;
    logic [CFG_W-1:0] repeat_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] address;
    logic [7:0] command;
  } req_t;

  typedef struct packed {
    logic carrier_on;
    logic busy;
    logic done;
    logic taken;
  } res_t;

  // Zero counts as one tick; values past the timer range saturate.
  function automatic logic [TIMER_BITS-1:0] seg_len(input logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] lim;
    ext = EXT_W'(v);
    lim = EXT_W'({TIMER_BITS{1'b1}});
    if (ext == '0) begin
      seg_len = TIMER_BITS'(1);
    end else if (ext > lim) begin
      seg_len = {TIMER_BITS{1'b1}};
    end else begin
      seg_len = TIMER_BITS'(ext);
    end
  endfunction

endpackage

// ----- rtl/core/irpd_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_sequencer: phase, bit shifter and segment timer
// Applies one item per enabled cycle and gives the result of that item.
// ----------------------------------------------------------------------------
module irpd_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          step_en,
  input  irpd_pkg::req_t req,
  input  irpd_pkg::cfg_t cfg,
  output irpd_pkg::res_t res
);
  import irpd_pkg::*;

  logic [3:0]            phase;
  logic [3:0]            phase_next;
  logic [FRAME_BITS-1:0] frame_bits;
  logic [FRAME_BITS-1:0] frame_bits_next;
  logic [BL_W-1:0]       bits_left;
  logic [BL_W-1:0]       bits_left_next;
  logic [TIMER_BITS-1:0] segment_timer;
  logic [TIMER_BITS-1:0] segment_timer_next;

  logic [WORD_W-1:0]     word;
  logic [BL_W-1:0]       bits_dec;
  logic                  busy;
  logic                  done;
  logic                  taken;

  assign busy = (phase >= PH_LEAD_MARK) && (phase <= PH_REP_GAP);
  assign word = {req.address, ~req.address, req.command, ~req.command};
  assign bits_dec = bits_left - BL_W'(1);

  always_comb begin
    phase_next         = phase;
    frame_bits_next    = frame_bits;
    bits_left_next     = bits_left;
    segment_timer_next = segment_timer;
    done               = 1'b0;
    taken              = 1'b0;
    if (req.kind == KIND_TICK) begin
      if (busy) begin
        if (segment_timer[TIMER_BITS-1:1] != '0) begin
          segment_timer_next = segment_timer - TIMER_BITS'(1);
        end else begin
          unique case (phase)
            PH_LEAD_MARK: begin
              phase_next         = PH_LEAD_SPACE;
              segment_timer_next = seg_len(cfg.leader_space);
            end
            PH_LEAD_SPACE: begin
              phase_next         = PH_BIT_MARK;
              segment_timer_next = seg_len(cfg.unit_mark);
            end
            PH_BIT_MARK: begin
              phase_next         = PH_BIT_SPACE;
              segment_timer_next = frame_bits[FRAME_BITS-1] ? seg_len(cfg.long_space)
                                                            : seg_len(cfg.unit_mark);
            end
            PH_BIT_SPACE: begin
              frame_bits_next    = frame_bits << 1;
              bits_left_next     = bits_dec;
              phase_next         = (bits_dec == '0) ? PH_TRAIL_MARK : PH_BIT_MARK;
              segment_timer_next = seg_len(cfg.unit_mark);
            end
            PH_TRAIL_MARK: begin
              phase_next         = PH_FRAME_GAP;
              segment_timer_next = seg_len(cfg.frame_gap);
            end
            PH_REP_LEAD_MARK: begin
              phase_next         = PH_REP_SPACE;
              segment_timer_next = seg_len(cfg.repeat_space);
            end
            PH_REP_SPACE: begin
              phase_next         = PH_REP_MARK;
              segment_timer_next = seg_len(cfg.unit_mark);
            end
            PH_REP_MARK: begin
              phase_next         = PH_REP_GAP;
              segment_timer_next = seg_len(cfg.repeat_gap);
            end
            PH_FRAME_GAP, PH_REP_GAP: begin
              phase_next         = PH_IDLE;
              segment_timer_next = '0;
              done               = 1'b1;
            end
            default: begin
              phase_next         = PH_IDLE;
              segment_timer_next = '0;
            end
          endcase
        end
      end
    end else if (req.kind == KIND_FRAME && !busy) begin
      frame_bits_next    = word[WORD_W-1 -: FRAME_BITS];
      bits_left_next     = BL_W'(FRAME_BITS);
      phase_next         = PH_LEAD_MARK;
      segment_timer_next = seg_len(cfg.leader_mark);
      taken              = 1'b1;
    end else if (req.kind == KIND_REPEAT && !busy) begin
      phase_next         = PH_REP_LEAD_MARK;
      segment_timer_next = seg_len(cfg.leader_mark);
      taken              = 1'b1;
    end
  end

  always_comb begin
    res.carrier_on = (phase_next == PH_LEAD_MARK) || (phase_next == PH_BIT_MARK) ||
                     (phase_next == PH_TRAIL_MARK) || (phase_next == PH_REP_LEAD_MARK) ||
                     (phase_next == PH_REP_MARK);
    res.busy  = (phase_next >= PH_LEAD_MARK) && (phase_next <= PH_REP_GAP);
    res.done  = done;
    res.taken = taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_bits    <= '0;
      bits_left     <= '0;
      segment_timer <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      frame_bits    <= frame_bits_next;
      bits_left     <= bits_left_next;
      segment_timer <= segment_timer_next;
    end
  end

endmodule

// ----- rtl/core/ir_pulse_distance_transmitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter: pulse-distance IR carrier sequencer
// Leader, 32 address/command bits MSB first, trailer and gap, or a short
// repeat code, all timed in microsecond tick words.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_stall    | kind, address, command
//  output   | out_valid / out_stall  | carrier_on, busy_res, sequence_done,
//           |                        | request_taken
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per cycle while the output is not stalled; each result leaves
// through an input register and a result register, with the sequencer
// step logic between them.
// Synchronous active-high reset empties both stages, idles the sequencer and
// restores register defaults. A stalled output holds the result register and
// the input register; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    address,
  input  logic [7:0]                    command,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          carrier_on,
  output logic                          busy_res,
  output logic                          sequence_done,
  output logic                          request_taken,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irpd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [irpd_pkg::CFG_W-1:0]    cfg_data
);
  import irpd_pkg::*;

  cfg_t cfg;
  req_t s1_req;
  logic s1_valid;
  logic advance;
  logic step_en;
  res_t res_next;

  // Always writable; user must issue writes only while idle, unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_mark    <= RST_UNIT;
      cfg.long_space   <= RST_LONG;
      cfg.leader_mark  <= RST_LEAD_MARK;
      cfg.leader_space <= RST_LEAD_SPACE;
      cfg.repeat_space <= RST_REP_SPACE;
      cfg.frame_gap    <= RST_FRAME_GAP;
      cfg.repeat_gap   <= RST_REP_GAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_UNIT:       cfg.unit_mark    <= cfg_data;
        REG_LONG:       cfg.long_space   <= cfg_data;
        REG_LEAD_MARK:  cfg.leader_mark  <= cfg_data;
        REG_LEAD_SPACE: cfg.leader_space <= cfg_data;
        REG_REP_SPACE:  cfg.repeat_space <= cfg_data;
        REG_FRAME_GAP:  cfg.frame_gap    <= cfg_data;
        REG_REP_GAP:    cfg.repeat_gap   <= cfg_data;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  // Advance the pipe whenever the result register is free or being taken.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign step_en  = s1_valid && advance;

  // Input register: load whenever the held word moves on or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req.kind    <= kind;
      s1_req.address <= address;
      s1_req.command <= command;
    end
  end

  irpd_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .req     (s1_req),
    .cfg     (cfg),
    .res     (res_next)
  );

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      carrier_on    <= res_next.carrier_on;
      busy_res      <= res_next.busy;
      sequence_done <= res_next.done;
      request_taken <= res_next.taken;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the IR pulse-distance transmitter
// Streams tick and start words into the block, predicts every result word
// from a cycle-free model of the carrier sequencer, and compares each output
// word field by field. Register settings change only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import irpd_pkg::*;

  // kind code that the block must ignore
  localparam logic [1:0]       KIND_NOP   = 2'd3;
  // register index past the last register; the write must be dropped
  localparam logic [CIDX_W-1:0] REG_NONE  = 3'd7;
  localparam logic [CFG_W-1:0] CFG_MAX    = '1;
  localparam int               TIMER_MAX  = (1 << TIMER_BITS) - 1;
  localparam int               QUIET_TAIL = 150;
  localparam int               DEAD_LIMIT = 4000;

  typedef enum logic [1:0] {OP_WORD, OP_WRITE, OP_DRAIN} plan_op_t;

  typedef struct {
    plan_op_t             op;
    logic [1:0]           kind;
    logic [7:0]           addr;
    logic [7:0]           cmd;
    logic [CIDX_W-1:0]    idx;
    logic [CFG_W-1:0]     data;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        kind      = KIND_TICK;
  logic [7:0]        address   = '0;
  logic [7:0]        command   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              carrier_on;
  logic              busy_res;
  logic              sequence_done;
  logic              request_taken;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  ir_pulse_distance_transmitter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .address       (address),
    .command       (command),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .carrier_on    (carrier_on),
    .busy_res      (busy_res),
    .sequence_done (sequence_done),
    .request_taken (request_taken),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus plan and shared bookkeeping
  // --------------------------------------------------------------------------
  step_t plan [$];            // words, register writes and drain points
  res_t  carrier_levels [$];  // predicted result words, oldest first
  int    word_count = 0;
  int    errors = 0;
  int    results_seen = 0;
  logic  quiet = 1'b0;        // no idling on either side once set
  logic  in_fire = 1'b0;      // input word taken at the last rising edge
  logic  cfg_fire = 1'b0;     // register write taken at the last rising edge

  // register copy used while building the plan, to size each sequence
  logic [CFG_W-1:0] plan_cfg [0:6];

  // --------------------------------------------------------------------------
  // Carrier sequencer model
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]      ir_cfg [0:6];
  logic [3:0]            ir_phase;
  logic [31:0]           ir_bits;
  logic [5:0]            ir_left;
  logic [TIMER_BITS-1:0] ir_timer;

  // A zero length still lasts one tick; lengths past the timer saturate.
  function automatic int seg_ticks(input logic [CFG_W-1:0] v);
    int t;
    t = int'(v);
    if (t == 0) t = 1;
    if (t > TIMER_MAX) t = TIMER_MAX;
    return t;
  endfunction

  function automatic logic in_sequence(input logic [3:0] ph);
    return ph >= PH_LEAD_MARK && ph <= PH_REP_GAP;
  endfunction

  task automatic open_segment(input logic [3:0] ph, input logic [CIDX_W-1:0] idx);
    ir_phase = ph;
    ir_timer = TIMER_BITS'(seg_ticks(ir_cfg[idx]));
  endtask

  // Advance the model by one input word and return the result word it causes.
  task automatic predict_levels(input logic [1:0] k, input logic [7:0] a,
                                input logic [7:0] c, output res_t r);
    logic was_busy;
    logic finished;
    was_busy = in_sequence(ir_phase);
    finished = 1'b0;
    r.taken = 1'b0;
    if (k == KIND_TICK) begin
      if (was_busy && ir_timer > 1) begin
        ir_timer = ir_timer - 1'b1;
      end else if (was_busy) begin
        // current segment has run out: move to the next one
        case (ir_phase)
          PH_LEAD_MARK:     open_segment(PH_LEAD_SPACE, REG_LEAD_SPACE);
          PH_LEAD_SPACE:    open_segment(PH_BIT_MARK, REG_UNIT);
          PH_BIT_MARK:      open_segment(PH_BIT_SPACE, ir_bits[31] ? REG_LONG : REG_UNIT);
          PH_BIT_SPACE: begin
            ir_bits = ir_bits << 1;
            ir_left = ir_left - 1'b1;
            if (ir_left == 0) open_segment(PH_TRAIL_MARK, REG_UNIT);
            else open_segment(PH_BIT_MARK, REG_UNIT);
          end
          PH_TRAIL_MARK:    open_segment(PH_FRAME_GAP, REG_FRAME_GAP);
          PH_REP_LEAD_MARK: open_segment(PH_REP_SPACE, REG_REP_SPACE);
          PH_REP_SPACE:     open_segment(PH_REP_MARK, REG_UNIT);
          PH_REP_MARK:      open_segment(PH_REP_GAP, REG_REP_GAP);
          PH_FRAME_GAP, PH_REP_GAP: begin
            ir_phase = PH_IDLE;
            ir_timer = '0;
            finished = 1'b1;
          end
          default: begin
            ir_phase = PH_IDLE;
            ir_timer = '0;
          end
        endcase
      end
    end else if (k == KIND_FRAME && !was_busy) begin
      ir_bits = {a, ~a, c, ~c};
      ir_left = 6'(FRAME_BITS);
      open_segment(PH_LEAD_MARK, REG_LEAD_MARK);
      r.taken = 1'b1;
    end else if (k == KIND_REPEAT && !was_busy) begin
      open_segment(PH_REP_LEAD_MARK, REG_LEAD_MARK);
      r.taken = 1'b1;
    end
    r.carrier_on = ir_phase inside {PH_LEAD_MARK, PH_BIT_MARK, PH_TRAIL_MARK,
                                    PH_REP_LEAD_MARK, PH_REP_MARK};
    r.busy = in_sequence(ir_phase);
    r.done = finished;
  endtask

  // --------------------------------------------------------------------------
  // Plan building
  // --------------------------------------------------------------------------
  task automatic add_word(input logic [1:0] k, input logic [7:0] a, input logic [7:0] c);
    step_t s;
    s.op = OP_WORD;
    s.kind = k;
    s.addr = a;
    s.cmd = c;
    s.idx = '0;
    s.data = '0;
    plan.push_back(s);
    word_count++;
  endtask

  task automatic set_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    step_t s;
    s.op = OP_WRITE;
    s.kind = KIND_TICK;
    s.addr = '0;
    s.cmd = '0;
    s.idx = idx;
    s.data = v;
    plan.push_back(s);
    if (idx <= REG_REP_GAP) plan_cfg[idx] = v;
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic drain_point();
    step_t s;
    s.op = OP_DRAIN;
    s.kind = KIND_TICK;
    s.addr = '0;
    s.cmd = '0;
    s.idx = '0;
    s.data = '0;
    plan.push_back(s);
  endtask

  task automatic set_all_registers(input logic [CFG_W-1:0] v);
    for (int r = 0; r <= int'(REG_REP_GAP); r++) set_register(CIDX_W'(r), v);
  endtask

  function automatic int frame_length(input logic [7:0] a, input logic [7:0] c);
    logic [31:0] w;
    int t;
    w = {a, ~a, c, ~c};
    t = seg_ticks(plan_cfg[REG_LEAD_MARK]) + seg_ticks(plan_cfg[REG_LEAD_SPACE]);
    for (int i = 31; i >= 32 - FRAME_BITS; i--) begin
      t += seg_ticks(plan_cfg[REG_UNIT]);
      t += w[i] ? seg_ticks(plan_cfg[REG_LONG]) : seg_ticks(plan_cfg[REG_UNIT]);
    end
    return t + seg_ticks(plan_cfg[REG_UNIT]) + seg_ticks(plan_cfg[REG_FRAME_GAP]);
  endfunction

  function automatic int repeat_length();
    return seg_ticks(plan_cfg[REG_LEAD_MARK]) + seg_ticks(plan_cfg[REG_REP_SPACE]) +
           seg_ticks(plan_cfg[REG_UNIT]) + seg_ticks(plan_cfg[REG_REP_GAP]);
  endfunction

  // One full sequence: the start word, exactly enough ticks to bring the block
  // back to idle, stray start and no-op words sprinkled in, and a few idle ticks.
  task automatic send_request(input logic [1:0] k, input logic [7:0] a, input logic [7:0] c,
                              input int noise_pct, input logic poke_busy);
    int n;
    add_word(k, a, c);
    if (poke_busy) begin
      add_word(KIND_FRAME, ~a, c);
      add_word(KIND_REPEAT, a, ~c);
      add_word(KIND_NOP, a, c);
    end
    n = (k == KIND_FRAME) ? frame_length(a, c) : repeat_length();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        add_word(2'($urandom_range(KIND_FRAME, KIND_NOP)), 8'($urandom), 8'($urandom));
      add_word(KIND_TICK, 8'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(0, 2)) add_word(KIND_TICK, 8'($urandom), 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: build the plan, release reset, wait for the end
  // --------------------------------------------------------------------------
  initial begin
    plan_cfg[REG_UNIT]       = RST_UNIT;
    plan_cfg[REG_LONG]       = RST_LONG;
    plan_cfg[REG_LEAD_MARK]  = RST_LEAD_MARK;
    plan_cfg[REG_LEAD_SPACE] = RST_LEAD_SPACE;
    plan_cfg[REG_REP_SPACE]  = RST_REP_SPACE;
    plan_cfg[REG_FRAME_GAP]  = RST_FRAME_GAP;
    plan_cfg[REG_REP_GAP]    = RST_REP_GAP;

    // Directed part. Ticks and ignored kinds while idle first.
    add_word(KIND_TICK, 8'h00, 8'h00);
    add_word(KIND_NOP, 8'hFF, 8'hFF);

    // Short unit lengths, longer space for a one; the write past the last
    // register must leave everything alone.
    drain_point();
    set_all_registers(17'd1);
    set_register(REG_LONG, 17'd2);
    set_register(REG_NONE, CFG_MAX);
    // Frames with the address and command extremes, starts while busy,
    // then a repeat code.
    send_request(KIND_FRAME, 8'h00, 8'hFF, 0, 1'b1);
    send_request(KIND_FRAME, 8'hFF, 8'h00, 0, 1'b0);
    send_request(KIND_REPEAT, 8'hA5, 8'h5A, 0, 1'b1);

    // Zero lengths must behave as one tick.
    drain_point();
    set_all_registers('0);
    send_request(KIND_FRAME, 8'hA5, 8'h3C, 0, 1'b0);
    send_request(KIND_REPEAT, 8'h3C, 8'hA5, 0, 1'b1);

    // Every register at its top value while idle; nothing may move.
    drain_point();
    set_all_registers(CFG_MAX);
    add_word(KIND_TICK, 8'h5A, 8'hC3);
    add_word(KIND_NOP, 8'h00, 8'hFF);

    // Random part: short random lengths, mixed frames and repeats, noise.
    while (word_count < 400) begin
      drain_point();
      for (int r = 0; r <= int'(REG_REP_GAP); r++)
        set_register(CIDX_W'(r), ($urandom_range(0, 15) == 0) ? 17'd0 :
                                 CFG_W'($urandom_range(1, 4)));
      send_request($urandom_range(0, 1) ? KIND_FRAME : KIND_REPEAT,
                   8'($urandom), 8'($urandom), 5, $urandom_range(0, 3) == 0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (plan.size() != 0 || in_valid || cfg_valid || carrier_levels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (carrier_levels.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, carrier_levels.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present one plan step at a time on the falling edge
  // --------------------------------------------------------------------------
  int    gap_left = 0;
  logic  drive_in;
  logic  drive_cfg;
  step_t head;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      // keep a word up until it is taken; drop it right after
      drive_in = in_valid && !in_fire;
      drive_cfg = cfg_valid && !cfg_fire;
      if (!drive_in && !drive_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (plan.size() != 0) begin
          head = plan[0];
          case (head.op)
            OP_DRAIN: begin
              if (carrier_levels.size() == 0) void'(plan.pop_front());
            end
            OP_WRITE: begin
              drive_cfg = 1'b1;
              cfg_index <= head.idx;
              cfg_data <= head.data;
              void'(plan.pop_front());
            end
            default: begin
              if (!quiet && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 11);
              end else begin
                drive_in = 1'b1;
                kind <= head.kind;
                address <= head.addr;
                command <= head.cmd;
                void'(plan.pop_front());
              end
            end
          endcase
        end
      end
      in_valid <= drive_in;
      cfg_valid <= drive_cfg;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off while the sender
  // keeps offering words so that both stages of the block fill up
  // --------------------------------------------------------------------------
  int   stall_left = 0;
  logic held_long = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held_long && results_seen >= 150 && in_valid) begin
        stall_left = 80;
        held_long = 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result words, track register writes, predict new words
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
    end
  endtask

  res_t want_word;
  res_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      ir_cfg[REG_UNIT]       = RST_UNIT;
      ir_cfg[REG_LONG]       = RST_LONG;
      ir_cfg[REG_LEAD_MARK]  = RST_LEAD_MARK;
      ir_cfg[REG_LEAD_SPACE] = RST_LEAD_SPACE;
      ir_cfg[REG_REP_SPACE]  = RST_REP_SPACE;
      ir_cfg[REG_FRAME_GAP]  = RST_FRAME_GAP;
      ir_cfg[REG_REP_GAP]    = RST_REP_GAP;
      ir_phase = PH_IDLE;
      ir_bits = '0;
      ir_left = '0;
      ir_timer = '0;
      results_seen = 0;
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (carrier_levels.size() == 0) begin
          errors++;
          $display("%0t: result word mismatch, expected none, actual %0b%0b%0b%0b",
                   $time, carrier_on, busy_res, sequence_done, request_taken);
        end else begin
          want_word = carrier_levels.pop_front();
          check_field("carrier_on", want_word.carrier_on, carrier_on);
          check_field("busy_res", want_word.busy, busy_res);
          check_field("sequence_done", want_word.done, sequence_done);
          check_field("request_taken", want_word.taken, request_taken);
        end
      end
      // writes past the last register are dropped by the block
      if (cfg_valid && cfg_ready && cfg_index <= REG_REP_GAP) ir_cfg[cfg_index] = cfg_data;
      if (in_valid && !in_stall) begin
        predict_levels(kind, address, command, next_word);
        carrier_levels.push_back(next_word);
      end
      in_fire <= in_valid && !in_stall;
      cfg_fire <= cfg_valid && cfg_ready;
      quiet <= plan.size() < QUIET_TAIL;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no handshake completes for too long
  // --------------------------------------------------------------------------
  int dead_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= DEAD_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

endmodule

// ----- ir_pulse_distance_transmitter.f -----
rtl/core/irpd_pkg.sv
rtl/core/irpd_sequencer.sv
rtl/core/ir_pulse_distance_transmitter.sv
dv/tb.sv
